### hw/rtl/hmt_pkg.sv
// Package for the heartbeat membership table: field widths, codes,
// table row and result types shared by the RTL. No dependencies.
`default_nettype none

package hmt_pkg;

    localparam int IdW    = 32;
    localparam int PortW  = 16;
    localparam int BeatW  = 32;
    localparam int TimeW  = 32;
    localparam int CfgDataW = 32;

    localparam logic [TimeW-1:0]    BUMP_AFTER       = 32'd3;
    localparam logic [IdW-1:0]      OWN_ID_RESET     = 32'd1;
    localparam logic [PortW-1:0]    OWN_PORT_RESET   = 16'd0;
    localparam logic [TimeW-1:0]    FAIL_TO_RESET    = 32'd5;
    localparam logic [TimeW-1:0]    REMOVE_TO_RESET  = 32'd20;

    typedef enum logic [1:0] {
        OP_MERGE = 2'd0,
        OP_REPLY = 2'd1,
        OP_BUMP  = 2'd2,
        OP_DUMP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_ENTRY     = 3'd5,
        ST_SKIPPED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_OWN_ID    = 2'd0,
        REG_OWN_PORT  = 2'd1,
        REG_FAIL_TO   = 2'd2,
        REG_REMOVE_TO = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND0,
        S_FIND,
        S_RESP,
        S_DUMP0,
        S_DUMP,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [PortW-1:0] port;
        logic [BeatW-1:0] beat;
        logic [TimeW-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [IdW-1:0]   own_id;
        logic [PortW-1:0] own_port;
        logic [TimeW-1:0] fail_to;
        logic [TimeW-1:0] remove_to;
    } cfg_t;

    typedef struct packed {
        logic             push;
        status_t          status;
        logic [IdW-1:0]   id;
        logic [PortW-1:0] port;
        logic [BeatW-1:0] beat;
        logic             last;
    } res_t;

    function automatic logic [BeatW-1:0] sat_inc(input logic [BeatW-1:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hmt_if.sv
// Channel interfaces of the heartbeat membership table: request, result
// and configuration write channels. Depends on hmt_pkg for widths.
`default_nettype none

interface hmt_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [hmt_pkg::IdW-1:0]    member_key_id;
    logic [hmt_pkg::PortW-1:0]  member_key_port;
    logic [hmt_pkg::BeatW-1:0]  beat_in;
    logic [hmt_pkg::TimeW-1:0]  now;

    modport source (output valid, op, member_key_id, member_key_port, beat_in, now,
                    input ready);
    modport sink   (input valid, op, member_key_id, member_key_port, beat_in, now,
                    output ready);
endinterface

interface hmt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [hmt_pkg::IdW-1:0]    out_id;
    logic [hmt_pkg::PortW-1:0]  out_port;
    logic [hmt_pkg::BeatW-1:0]  out_beat;
    logic                       last;

    modport source (output valid, status, out_id, out_port, out_beat, last,
                    input ready);
    modport sink   (input valid, status, out_id, out_port, out_beat, last,
                    output ready);
endinterface

interface hmt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    index;
    logic [hmt_pkg::CfgDataW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/hmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module hmt_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hmt_out.sv
// Result output register of the membership table: holds one word until
// the sink takes it. Depends on hmt_pkg and hmt_if.
`default_nettype none

module hmt_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hmt_pkg::res_t res,
    output logic               can_push,
    hmt_rsp_if.source          rsp
);

    logic                          valid_reg;
    hmt_pkg::status_t              status_reg;
    logic [hmt_pkg::IdW-1:0]       id_reg;
    logic [hmt_pkg::PortW-1:0]     port_reg;
    logic [hmt_pkg::BeatW-1:0]     beat_reg;
    logic                          last_reg;

    assign can_push = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            status_reg <= res.status;
            id_reg     <= res.id;
            port_reg   <= res.port;
            beat_reg   <= res.beat;
            last_reg   <= res.last;
        end
    end

    assign rsp.valid    = valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.out_id   = id_reg;
    assign rsp.out_port = port_reg;
    assign rsp.out_beat = beat_reg;
    assign rsp.last     = last_reg;

endmodule

`default_nettype wire

### hw/rtl/hmt_ctrl.sv
// Sequencer of the membership table: search, update, append and dump
// compaction over the entry RAM. Depends on hmt_pkg and hmt_if.
`default_nettype none

module hmt_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hmt_pkg::cfg_t                    cfg,
    hmt_req_if.sink                               req,
    output hmt_pkg::res_t                         res,
    input  wire logic                             can_push,
    output logic                                  ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_waddr,
    output hmt_pkg::entry_t                       ram_wdata,
    output logic                                  ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_raddr,
    input  wire hmt_pkg::entry_t                  ram_rdata,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    hmt_pkg::state_t               state_reg, state_next;
    hmt_pkg::op_t                  op_reg, op_next;
    logic [hmt_pkg::IdW-1:0]       key_id_reg, key_id_next;
    logic [hmt_pkg::PortW-1:0]     key_port_reg, key_port_next;
    logic [hmt_pkg::BeatW-1:0]     beat_reg, beat_next;
    logic [hmt_pkg::TimeW-1:0]     now_reg, now_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 wptr_reg, wptr_next;
    logic [hmt_pkg::BeatW-1:0]     own_beat_reg, own_beat_next;
    logic [hmt_pkg::TimeW-1:0]     own_stamp_reg, own_stamp_next;
    hmt_pkg::status_t              resp_reg, resp_next;
    logic [hmt_pkg::IdW-1:0]       held_id_reg, held_id_next;
    logic [hmt_pkg::PortW-1:0]     held_port_reg, held_port_next;
    logic [hmt_pkg::BeatW-1:0]     held_beat_reg, held_beat_next;

    logic                          own_hit;
    logic                          row_hit;
    logic                          at_end;
    logic [AW-1:0]                 idx_inc;
    logic [hmt_pkg::TimeW-1:0]     age;
    logic                          keep;
    logic                          alive;
    logic                          hit_we;
    hmt_pkg::entry_t               hit_wdata;
    hmt_pkg::status_t              hit_status;
    logic                          miss_we;
    hmt_pkg::entry_t               miss_wdata;
    hmt_pkg::status_t              miss_status;
    logic                          is_merge;

    assign entry_count = cnt_reg;

    always_comb
    begin
        is_merge = (op_reg == hmt_pkg::OP_MERGE);
        own_hit  = (cfg.own_id == key_id_reg) && (cfg.own_port == key_port_reg);
        row_hit  = (ram_rdata.id == key_id_reg) && (ram_rdata.port == key_port_reg);
        at_end   = (CW'(idx_reg) + CW'(1) == cnt_reg);
        idx_inc  = idx_reg + AW'(1);
        age      = now_reg - ram_rdata.stamp;
        keep     = !(age > cfg.remove_to);
        alive    = keep && !(age > cfg.fail_to);

        // update of a matching row held in the RAM
        hit_wdata       = ram_rdata;
        hit_wdata.stamp = now_reg;
        if (is_merge)
        begin
            hit_we         = beat_reg > ram_rdata.beat;
            hit_wdata.beat = beat_reg;
            hit_status     = hit_we ? hmt_pkg::ST_UPDATED : hmt_pkg::ST_UNCHANGED;
        end
        else
        begin
            hit_we         = 1'b1;
            hit_wdata.beat = hmt_pkg::sat_inc(ram_rdata.beat);
            hit_status     = hmt_pkg::ST_UPDATED;
        end

        // append of a member not in the table
        miss_wdata.id    = key_id_reg;
        miss_wdata.port  = key_port_reg;
        miss_wdata.beat  = beat_reg;
        miss_wdata.stamp = now_reg;
        if (is_merge)
        begin
            miss_we     = (cnt_reg != CW'(TABLE_DEPTH));
            miss_status = miss_we ? hmt_pkg::ST_INSERTED : hmt_pkg::ST_FULL;
        end
        else
        begin
            miss_we     = 1'b0;
            miss_status = hmt_pkg::ST_NOTFOUND;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_id_next    = key_id_reg;
        key_port_next  = key_port_reg;
        beat_next      = beat_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        own_beat_next  = own_beat_reg;
        own_stamp_next = own_stamp_reg;
        resp_next      = resp_reg;
        held_id_next   = held_id_reg;
        held_port_next = held_port_reg;
        held_beat_next = held_beat_reg;

        req.ready  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        res        = '0;
        res.status = hmt_pkg::ST_ENTRY;

        case (state_reg)
            hmt_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next       = hmt_pkg::op_t'(req.op);
                    key_id_next   = req.member_key_id;
                    key_port_next = req.member_key_port;
                    beat_next     = req.beat_in;
                    now_next      = req.now;
                    case (hmt_pkg::op_t'(req.op))
                        hmt_pkg::OP_BUMP:
                        begin
                            if (req.now > hmt_pkg::BUMP_AFTER && cnt_reg > CW'(1))
                            begin
                                own_beat_next  = hmt_pkg::sat_inc(own_beat_reg);
                                own_stamp_next = req.now;
                                resp_next      = hmt_pkg::ST_UPDATED;
                            end
                            else
                            begin
                                resp_next = hmt_pkg::ST_SKIPPED;
                            end
                            state_next = hmt_pkg::S_RESP;
                        end
                        hmt_pkg::OP_DUMP:
                        begin
                            state_next = hmt_pkg::S_DUMP0;
                        end
                        default:
                        begin
                            state_next = hmt_pkg::S_FIND0;
                        end
                    endcase
                end
            end

            hmt_pkg::S_FIND0:
            begin
                // entry zero lives in registers, not in the RAM
                if (own_hit)
                begin
                    if (is_merge)
                    begin
                        if (beat_reg > own_beat_reg)
                        begin
                            own_beat_next  = beat_reg;
                            own_stamp_next = now_reg;
                            resp_next      = hmt_pkg::ST_UPDATED;
                        end
                        else
                        begin
                            resp_next = hmt_pkg::ST_UNCHANGED;
                        end
                    end
                    else
                    begin
                        own_beat_next  = hmt_pkg::sat_inc(own_beat_reg);
                        own_stamp_next = now_reg;
                        resp_next      = hmt_pkg::ST_UPDATED;
                    end
                    state_next = hmt_pkg::S_RESP;
                end
                else if (cnt_reg > CW'(1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = hmt_pkg::S_FIND;
                end
                else
                begin
                    ram_we     = miss_we;
                    ram_waddr  = cnt_reg[AW-1:0];
                    ram_wdata  = miss_wdata;
                    cnt_next   = cnt_reg + CW'(miss_we);
                    resp_next  = miss_status;
                    state_next = hmt_pkg::S_RESP;
                end
            end

            hmt_pkg::S_FIND:
            begin
                if (row_hit)
                begin
                    ram_we     = hit_we;
                    ram_waddr  = idx_reg;
                    ram_wdata  = hit_wdata;
                    resp_next  = hit_status;
                    state_next = hmt_pkg::S_RESP;
                end
                else if (at_end)
                begin
                    ram_we     = miss_we;
                    ram_waddr  = cnt_reg[AW-1:0];
                    ram_wdata  = miss_wdata;
                    cnt_next   = cnt_reg + CW'(miss_we);
                    resp_next  = miss_status;
                    state_next = hmt_pkg::S_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end

            hmt_pkg::S_RESP:
            begin
                res.push   = can_push;
                res.status = resp_reg;
                res.last   = 1'b1;
                if (can_push)
                begin
                    state_next = hmt_pkg::S_IDLE;
                end
            end

            hmt_pkg::S_DUMP0:
            begin
                // own entry is always listed; hold it until the last flag is known
                held_id_next   = cfg.own_id;
                held_port_next = cfg.own_port;
                held_beat_next = own_beat_reg;
                wptr_next      = CW'(1);
                if (cnt_reg > CW'(1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = hmt_pkg::S_DUMP;
                end
                else
                begin
                    state_next = hmt_pkg::S_FLUSH;
                end
            end

            hmt_pkg::S_DUMP:
            begin
                // for a live row, stall with the read data held until the held word can go
                if (!alive || can_push)
                begin
                    if (alive)
                    begin
                        res.push       = 1'b1;
                        res.id         = held_id_reg;
                        res.port       = held_port_reg;
                        res.beat       = held_beat_reg;
                        held_id_next   = ram_rdata.id;
                        held_port_next = ram_rdata.port;
                        held_beat_next = ram_rdata.beat;
                    end
                    if (keep)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wptr_reg[AW-1:0];
                        ram_wdata = ram_rdata;
                        wptr_next = wptr_reg + CW'(1);
                    end
                    if (at_end)
                    begin
                        cnt_next   = wptr_reg + CW'(keep);
                        state_next = hmt_pkg::S_FLUSH;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc;
                        idx_next  = idx_inc;
                    end
                end
            end

            hmt_pkg::S_FLUSH:
            begin
                res.push = can_push;
                res.id   = held_id_reg;
                res.port = held_port_reg;
                res.beat = held_beat_reg;
                res.last = 1'b1;
                if (can_push)
                begin
                    state_next = hmt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmt_pkg::S_IDLE;
            cnt_reg       <= CW'(1);
            own_beat_reg  <= '0;
            own_stamp_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            own_beat_reg  <= own_beat_next;
            own_stamp_reg <= own_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_id_reg    <= key_id_next;
        key_port_reg  <= key_port_next;
        beat_reg      <= beat_next;
        now_reg       <= now_next;
        idx_reg       <= idx_next;
        wptr_reg      <= wptr_next;
        resp_reg      <= resp_next;
        held_id_reg   <= held_id_next;
        held_port_reg <= held_port_next;
        held_beat_reg <= held_beat_next;
    end

endmodule

`default_nettype wire

### hw/rtl/heartbeat_membership_table_top.sv
// Heartbeat membership table, one item at a time. Bump: no RAM access.
// Merge and reply: one RAM read per entry searched on the single read
// port. Dump: one entry per cycle unless the output stalls, compacted in
// place through the write port.
// Reset: registers to defaults, entry count one, own heartbeat and stamp
// zero; the entry RAM is not cleared, only rows below the count are read.
`default_nettype none

module heartbeat_membership_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hmt_req_if.sink    req,
    hmt_rsp_if.source  rsp,
    hmt_cfg_if.sink    cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    hmt_pkg::cfg_t    cfg_reg;
    hmt_pkg::res_t    res;
    logic             can_push;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    hmt_pkg::entry_t  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    hmt_pkg::entry_t  ram_rdata;
    logic [CW-1:0]    entry_count;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id    <= hmt_pkg::OWN_ID_RESET;
            cfg_reg.own_port  <= hmt_pkg::OWN_PORT_RESET;
            cfg_reg.fail_to   <= hmt_pkg::FAIL_TO_RESET;
            cfg_reg.remove_to <= hmt_pkg::REMOVE_TO_RESET;
        end
        else if (cfg.valid)
        begin
            case (hmt_pkg::cfg_idx_t'(cfg.index))
                hmt_pkg::REG_OWN_ID:    cfg_reg.own_id    <= cfg.data;
                hmt_pkg::REG_OWN_PORT:  cfg_reg.own_port  <= cfg.data[hmt_pkg::PortW-1:0];
                hmt_pkg::REG_FAIL_TO:   cfg_reg.fail_to   <= cfg.data;
                hmt_pkg::REG_REMOVE_TO: cfg_reg.remove_to <= cfg.data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    hmt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req         (req),
        .res         (res),
        .can_push    (can_push),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .entry_count (entry_count)
    );

    hmt_ram #(
        .WIDTH ($bits(hmt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hmt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_push (can_push),
        .rsp      (rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an item is in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count >= CW'(1)) && (entry_count <= CW'(TABLE_DEPTH)))
        else $error("entry count out of range");

    a_only_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (rsp.status == hmt_pkg::ST_ENTRY))
        else $error("non-final word that is not a list entry");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.push && rsp.valid && !rsp.ready))
        else $error("result pushed over a word still waiting");
`endif

endmodule

`default_nettype wire
